[hdl/esfr_pkg.sv]
// Shared types and constants for the escape-stuffing frame receiver.
package esfr_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 64;
    localparam int unsigned MTU_W            = 7;
    localparam int unsigned BYTE_W           = 8;

    localparam logic [MTU_W-1:0]  MTU_RESET  = 7'd64;
    localparam logic [BYTE_W-1:0] BYTE_START = 8'hE1;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'hE0;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h3D;
    localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'd64;

    typedef enum logic [1:0] {
        ST_UNSYNCED,
        ST_READING,
        ST_ESCAPED,
        ST_EMIT
    } state_t;

endpackage

[hdl/esfr_frame_ram.sv]
// Frame payload store: one write port, one registered read port.
module esfr_frame_ram
    import esfr_pkg::*;
#(
    parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
    parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [IDX_W-1:0]  raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/escape_stuffing_frame_receiver.sv]
// Top level of the escape-stuffing frame receiver: FSM, fill counter and output register.
// Output: the first payload transaction follows the end byte through the emit state,
// the store's registered read data and the output register; an empty-frame result is
// valid the cycle after the end byte. Throughput: one line byte per cycle while receiving
// and the output is not held; each store read waits for the last one to reach the output.
// Reset: asynchronous, active low; unsynced, mtu 64, output empty; frame store not cleared.
module escape_stuffing_frame_receiver
    import esfr_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mtu_we,
    input  logic [MTU_W-1:0]  mtu_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] frame_byte
    output logic              m_tlast,
    output logic              m_tuser    // [0] empty_frame
);

    localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [MTU_W-1:0] DEPTH_M = MTU_W'(BUFFER_DEPTH);

    state_t            state_reg, state_next;
    logic [MTU_W-1:0]  mtu_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_pending_reg;
    logic              rd_last_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_empty_reg;

    logic              s_fire;
    logic [MTU_W-1:0]  limit;
    logic              at_limit;
    logic              fill_zero;
    logic              rd_final;
    logic              issue;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    logic              load_empty;

    assign s_tready  = (state_reg != ST_EMIT) && !rd_pending_reg
                       && (!out_valid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign limit     = (mtu_reg > DEPTH_M) ? DEPTH_M : mtu_reg;
    assign at_limit  = (MTU_W'(fill_reg) >= limit);
    assign fill_zero = (fill_reg == '0);
    assign rd_final  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_reg);
    assign issue     = (state_reg == ST_EMIT) && !rd_pending_reg
                       && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_UNSYNCED:
            begin
                if (s_fire && (s_tdata == BYTE_START))
                begin
                    state_next = ST_READING;
                end
            end
            ST_READING:
            begin
                if (s_fire)
                begin
                    priority if (s_tdata == BYTE_END)
                    begin
                        state_next = fill_zero ? ST_UNSYNCED : ST_EMIT;
                    end
                    else if (s_tdata == BYTE_ESC)
                    begin
                        state_next = ST_ESCAPED;
                    end
                    else if (at_limit)
                    begin
                        state_next = ST_UNSYNCED;
                    end
                    else
                    begin
                        state_next = ST_READING;
                    end
                end
            end
            ST_ESCAPED:
            begin
                if (s_fire)
                begin
                    state_next = at_limit ? ST_UNSYNCED : ST_READING;
                end
            end
            ST_EMIT:
            begin
                if (issue && rd_final)
                begin
                    state_next = ST_UNSYNCED;
                end
            end
            default:
            begin
                state_next = ST_UNSYNCED;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        mem_we      = 1'b0;
        mem_wdata   = s_tdata;
        load_empty  = 1'b0;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_UNSYNCED:
            begin
                if (s_fire && (s_tdata == BYTE_START))
                begin
                    fill_next = '0;
                end
            end
            ST_READING:
            begin
                if (s_fire)
                begin
                    priority if (s_tdata == BYTE_END)
                    begin
                        load_empty  = fill_zero;
                        rd_idx_next = '0;
                    end
                    else if (s_tdata == BYTE_ESC)
                    begin
                        fill_next = fill_reg;
                    end
                    else if (at_limit)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_ESCAPED:
            begin
                mem_wdata = s_tdata - ESC_OFFSET;
                if (s_fire)
                begin
                    if (at_limit)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                fill_next = '0;
            end
        endcase
    end

    // writes and reads never meet on one entry: all writes of a frame precede its reads
    esfr_frame_ram #(
        .DEPTH (BUFFER_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IDX_W'(fill_reg)),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_UNSYNCED;
            mtu_reg        <= MTU_RESET;
            fill_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pending_reg <= issue;
            rd_last_reg    <= rd_final;
            if (mtu_we)
            begin
                mtu_reg <= mtu_wdata;
            end
            if (rd_pending_reg || load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pending_reg)
        begin
            out_data_reg  <= mem_rdata;
            out_last_reg  <= rd_last_reg;
            out_empty_reg <= 1'b0;
        end
        else if (load_empty)
        begin
            out_data_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

`ifndef SYNTHESIS
    a_read_lands_free : assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> !out_valid_reg)
        else $error("read data arrives while output register is occupied");

    a_no_input_emit : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !s_tready)
        else $error("input taken while emitting a frame");

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= CNT_W'(BUFFER_DEPTH)))
        else $error("fill count beyond store depth");

    a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
        load_empty |=> (m_tvalid && m_tlast && m_tuser && (m_tdata == '0)))
        else $error("empty frame result malformed");
`endif

endmodule
